[rtl/core/vector_cosine_l2_distance_macros.svh]
// Assertion macros for the checker of the vector distance block.
`ifndef VECTOR_COSINE_L2_DISTANCE_MACROS_SVH
`define VECTOR_COSINE_L2_DISTANCE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VCL2D_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VCL2D_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/vcl2d_pkg.sv]
`timescale 1ns / 1ps

package vcl2d_pkg;

   // Accumulator, multiplier and result widths.
   localparam int ACC_W   = 48;
   localparam int MUL_W   = 25;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int ROOT_W  = ACC_W / 2;
   localparam int COS_W   = 18;
   localparam int QUO_W   = 17;

   // Iteration counts of the square root and the division.
   localparam int SQRT_ITERS = ROOT_W;
   localparam int DIV_ITERS  = 16;
   localparam int IT_W       = $clog2(SQRT_ITERS);

   // Configuration port layout and register indexes.
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_METRIC_MODE = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DENOM   = 8'd1;

   // Metric mode codes.
   localparam logic MODE_L2     = 1'b0;
   localparam logic MODE_COSINE = 1'b1;

   // 1.0 in Q2.16.
   localparam logic [COS_W-1:0] ONE_Q16 = 18'd65536;

endpackage

[rtl/core/vcl2d_mult.sv]
`timescale 1ns / 1ps

// Shared signed multiplier with a registered product.
module vcl2d_mult
   import vcl2d_pkg::*;
(
   input  logic                     clock,
   input  logic signed [MUL_W-1:0]  op_a,
   input  logic signed [MUL_W-1:0]  op_b,
   output logic signed [PROD_W-1:0] prod_ff
);

   logic signed [PROD_W-1:0] prod_in;

   // The full product fits, so no truncation is needed.
   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

[rtl/core/vector_cosine_l2_distance.sv]
`timescale 1ns / 1ps
// An element beat is taken only in idle; the one shared multiplier forms its products
// in turn. The last beat of an L2 vector goes on to the output stage. The last beat of a
// cosine vector runs two 24-step square roots and, unless degenerate or clamped, a 16-step
// division on one compare-subtract unit. The result then sits in an output register.
// Reset is synchronous and active high: sums, count, flags and result valid clear, and the
// registers return to metric_mode 0 and min_denominator 1.
module vector_cosine_l2_distance
   import vcl2d_pkg::*;
#(
   parameter int ELEM_WIDTH = 16,
   parameter int MAX_DIM    = 4096
)
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [ELEM_WIDTH-1:0] req_elem_a,
   input  logic signed [ELEM_WIDTH-1:0] req_elem_b,
   input  logic                         req_last_element,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [ACC_W-1:0]             rsp_l2_distance,
   output logic [COS_W-1:0]             rsp_cosine_distance,
   output logic                         rsp_degenerate,
   output logic                         rsp_overflow,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   localparam int CNT_W = $clog2(MAX_DIM + 1);
   localparam int EXT_W = MUL_W - ELEM_WIDTH;

   typedef enum logic [3:0] {
      ST_IDLE, ST_L2_MUL, ST_L2_ADD, ST_CS_AB, ST_CS_AA, ST_CS_BB, ST_CS_NB,
      ST_SQ_INIT, ST_SQ_A, ST_SQ_B, ST_DEN_MUL, ST_DEN_CHK, ST_Q_CHK, ST_DIV,
      ST_COS_FORM, ST_EMIT
   } state_type;

   // Unsigned add that saturates at all ones; the top bit reports saturation.
   function automatic logic [ACC_W:0] add_u48(input logic [ACC_W-1:0] acc,
                                              input logic [PROD_W-1:0] x);
      logic [PROD_W:0] s;
      s = {{(PROD_W + 1 - ACC_W){1'b0}}, acc} + {1'b0, x};
      if (s[PROD_W:ACC_W] != '0) begin
         add_u48 = {1'b1, {ACC_W{1'b1}}};
      end else begin
         add_u48 = {1'b0, s[ACC_W-1:0]};
      end
   endfunction

   // Signed add that clamps to the 48-bit range; the top bit reports saturation.
   function automatic logic [ACC_W:0] add_s48(input logic [ACC_W-1:0] acc,
                                              input logic [PROD_W-1:0] x);
      logic [PROD_W:0] s;
      logic [PROD_W-ACC_W+1:0] top;
      s = {{(PROD_W + 1 - ACC_W){acc[ACC_W-1]}}, acc} + {x[PROD_W-1], x};
      top = s[PROD_W:ACC_W-1];
      if (!s[PROD_W] && top != '0) begin
         add_s48 = {1'b1, 1'b0, {(ACC_W - 1){1'b1}}};
      end else if (s[PROD_W] && top != '1) begin
         add_s48 = {1'b1, 1'b1, {(ACC_W - 1){1'b0}}};
      end else begin
         add_s48 = {1'b0, s[ACC_W-1:0]};
      end
   endfunction

   state_type                 state_ff;
   logic                      mode_cfg_ff;
   logic [CSR_DATA_W-1:0]     min_den_ff;
   logic                      mode_ff;
   logic                      last_ff;
   logic signed [MUL_W-1:0]   a_ff;
   logic signed [MUL_W-1:0]   b_ff;
   logic [ACC_W-1:0]          diff_sum_ff;
   logic [ACC_W-1:0]          dot_sum_ff;
   logic [ACC_W-1:0]          norm_a_ff;
   logic [ACC_W-1:0]          norm_b_ff;
   logic [CNT_W-1:0]          count_ff;
   logic                      sat_ff;
   logic [ACC_W:0]            wk_rem_ff;
   logic [ACC_W-1:0]          wk_root_ff;
   logic [IT_W-1:0]           it_ff;
   logic [ROOT_W-1:0]         root_a_ff;
   logic [ACC_W-1:0]          den_ff;
   logic                      neg_ff;
   logic [QUO_W-1:0]          q_ff;
   logic [COS_W-1:0]          res_cos_ff;
   logic                      res_degen_ff;
   logic                      rsp_valid_ff;
   logic [ACC_W-1:0]          rsp_l2_ff;
   logic [COS_W-1:0]          rsp_cos_ff;
   logic                      rsp_degen_ff;
   logic                      rsp_ovf_ff;

   logic signed [MUL_W-1:0]   mul_a;
   logic signed [MUL_W-1:0]   mul_b;
   logic signed [PROD_W-1:0]  prod;
   logic signed [MUL_W-1:0]   elem_a_ext;
   logic signed [MUL_W-1:0]   elem_b_ext;
   logic signed [MUL_W-1:0]   diff_ab;
   logic [ACC_W:0]            sum_diff;
   logic [ACC_W:0]            sum_dot;
   logic [ACC_W:0]            sum_na;
   logic [ACC_W:0]            sum_nb;
   logic [ACC_W-1:0]          sq_bit;
   logic [ACC_W:0]            cs_lhs;
   logic [ACC_W:0]            cs_rhs;
   logic [ACC_W+1:0]          cs_diff;
   logic                      cs_ge;
   logic [ACC_W-1:0]          sq_root_next;
   logic [ACC_W-1:0]          den_prod;
   logic [ACC_W-1:0]          dot_mag;
   logic                      count_full;
   logic                      accept;
   logic                      emit_go;
   state_type                 finish_state;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign emit_go   = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_l2_distance     = rsp_l2_ff;
   assign rsp_cosine_distance = rsp_cos_ff;
   assign rsp_degenerate      = rsp_degen_ff;
   assign rsp_overflow        = rsp_ovf_ff;

   // Element sign extension to the multiplier width.
   assign elem_a_ext = {{EXT_W{req_elem_a[ELEM_WIDTH-1]}}, req_elem_a};
   assign elem_b_ext = {{EXT_W{req_elem_b[ELEM_WIDTH-1]}}, req_elem_b};
   assign diff_ab    = a_ff - b_ff;
   assign count_full = (count_ff >= CNT_W'(MAX_DIM));

   // Where an element beat goes once its sums are updated.
   always_comb begin
      if (!last_ff) begin
         finish_state = ST_IDLE;
      end else if (mode_ff == MODE_COSINE) begin
         finish_state = ST_SQ_INIT;
      end else begin
         finish_state = ST_EMIT;
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      unique case (state_ff)
         ST_L2_MUL: begin
            mul_a = diff_ab;
            mul_b = diff_ab;
         end
         ST_CS_AB: begin
            mul_a = a_ff;
            mul_b = b_ff;
         end
         ST_CS_AA: begin
            mul_a = a_ff;
            mul_b = a_ff;
         end
         ST_CS_BB: begin
            mul_a = b_ff;
            mul_b = b_ff;
         end
         ST_DEN_MUL: begin
            mul_a = {{(MUL_W - ROOT_W){1'b0}}, root_a_ff};
            mul_b = {{(MUL_W - ROOT_W){1'b0}}, wk_root_ff[ROOT_W-1:0]};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   vcl2d_mult u_mult (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod)
   );

   // Saturating accumulation of the registered product.
   assign sum_diff = add_u48(diff_sum_ff, prod);
   assign sum_dot  = add_s48(dot_sum_ff, prod);
   assign sum_na   = add_u48(norm_a_ff, prod);
   assign sum_nb   = add_u48(norm_b_ff, prod);

   // Shared compare-subtract unit for the square root and the division steps.
   assign sq_bit = ACC_W'(1) << {it_ff, 1'b0};
   always_comb begin
      case (state_ff)
         ST_SQ_A, ST_SQ_B: begin
            cs_lhs = wk_rem_ff;
            cs_rhs = {1'b0, wk_root_ff} + {1'b0, sq_bit};
         end
         ST_DIV: begin
            cs_lhs = {wk_rem_ff[ACC_W-1:0], 1'b0};
            cs_rhs = {1'b0, den_ff};
         end
         default: begin
            cs_lhs = wk_rem_ff;
            cs_rhs = {1'b0, den_ff};
         end
      endcase
   end
   assign cs_diff      = {1'b0, cs_lhs} - {1'b0, cs_rhs};
   assign cs_ge        = !cs_diff[ACC_W+1];
   assign sq_root_next = cs_ge ? ((wk_root_ff >> 1) + sq_bit) : (wk_root_ff >> 1);

   assign den_prod = prod[ACC_W-1:0];
   assign dot_mag  = dot_sum_ff[ACC_W-1] ? (~dot_sum_ff + ACC_W'(1)) : dot_sum_ff;

   // Sequencer, configuration registers and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_cfg_ff  <= MODE_L2;
         min_den_ff   <= CSR_DATA_W'(1);
         diff_sum_ff  <= '0;
         dot_sum_ff   <= '0;
         norm_a_ff    <= '0;
         norm_b_ff    <= '0;
         count_ff     <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_METRIC_MODE: mode_cfg_ff <= csr_wdata[0];
               CSR_MIN_DENOM:   min_den_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end

         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  a_ff    <= elem_a_ext;
                  b_ff    <= elem_b_ext;
                  last_ff <= req_last_element;
                  mode_ff <= mode_cfg_ff;
                  if (count_full) begin
                     // Beats past the maximum length are dropped and flagged.
                     sat_ff <= 1'b1;
                     if (!req_last_element) begin
                        state_ff <= ST_IDLE;
                     end else if (mode_cfg_ff == MODE_COSINE) begin
                        state_ff <= ST_SQ_INIT;
                     end else begin
                        state_ff <= ST_EMIT;
                     end
                  end else begin
                     count_ff <= count_ff + CNT_W'(1);
                     state_ff <= (mode_cfg_ff == MODE_COSINE) ? ST_CS_AB : ST_L2_MUL;
                  end
               end
            end
            ST_L2_MUL: state_ff <= ST_L2_ADD;
            ST_L2_ADD: begin
               diff_sum_ff <= sum_diff[ACC_W-1:0];
               sat_ff      <= sat_ff | sum_diff[ACC_W];
               state_ff    <= finish_state;
            end
            ST_CS_AB: state_ff <= ST_CS_AA;
            ST_CS_AA: begin
               dot_sum_ff <= sum_dot[ACC_W-1:0];
               sat_ff     <= sat_ff | sum_dot[ACC_W];
               state_ff   <= ST_CS_BB;
            end
            ST_CS_BB: begin
               norm_a_ff <= sum_na[ACC_W-1:0];
               sat_ff    <= sat_ff | sum_na[ACC_W];
               state_ff  <= ST_CS_NB;
            end
            ST_CS_NB: begin
               norm_b_ff <= sum_nb[ACC_W-1:0];
               sat_ff    <= sat_ff | sum_nb[ACC_W];
               state_ff  <= finish_state;
            end
            ST_SQ_INIT: begin
               wk_rem_ff  <= {1'b0, norm_a_ff};
               wk_root_ff <= '0;
               it_ff      <= IT_W'(SQRT_ITERS - 1);
               state_ff   <= ST_SQ_A;
            end
            ST_SQ_A: begin
               if (it_ff == '0) begin
                  // First root done; start on the second norm.
                  root_a_ff  <= sq_root_next[ROOT_W-1:0];
                  wk_rem_ff  <= {1'b0, norm_b_ff};
                  wk_root_ff <= '0;
                  it_ff      <= IT_W'(SQRT_ITERS - 1);
                  state_ff   <= ST_SQ_B;
               end else begin
                  if (cs_ge) begin
                     wk_rem_ff <= cs_diff[ACC_W:0];
                  end
                  wk_root_ff <= sq_root_next;
                  it_ff      <= it_ff - IT_W'(1);
               end
            end
            ST_SQ_B: begin
               if (cs_ge) begin
                  wk_rem_ff <= cs_diff[ACC_W:0];
               end
               wk_root_ff <= sq_root_next;
               it_ff      <= it_ff - IT_W'(1);
               if (it_ff == '0) begin
                  state_ff <= ST_DEN_MUL;
               end
            end
            ST_DEN_MUL: state_ff <= ST_DEN_CHK;
            ST_DEN_CHK: begin
               den_ff    <= den_prod;
               neg_ff    <= dot_sum_ff[ACC_W-1];
               wk_rem_ff <= {1'b0, dot_mag};
               if (den_prod == '0 || den_prod < ACC_W'(min_den_ff)) begin
                  res_cos_ff   <= ONE_Q16;
                  res_degen_ff <= 1'b1;
                  state_ff     <= ST_EMIT;
               end else begin
                  res_degen_ff <= 1'b0;
                  state_ff     <= ST_Q_CHK;
               end
            end
            ST_Q_CHK: begin
               // A magnitude at or above the denominator clamps the quotient to 1.0.
               if (cs_ge) begin
                  q_ff     <= QUO_W'(ONE_Q16);
                  state_ff <= ST_COS_FORM;
               end else begin
                  q_ff     <= '0;
                  it_ff    <= IT_W'(DIV_ITERS - 1);
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               wk_rem_ff <= cs_ge ? cs_diff[ACC_W:0] : {wk_rem_ff[ACC_W-1:0], 1'b0};
               q_ff      <= {q_ff[QUO_W-2:0], cs_ge};
               it_ff     <= it_ff - IT_W'(1);
               if (it_ff == '0) begin
                  state_ff <= ST_COS_FORM;
               end
            end
            ST_COS_FORM: begin
               res_cos_ff <= neg_ff ? (ONE_Q16 + COS_W'(q_ff)) : (ONE_Q16 - COS_W'(q_ff));
               state_ff   <= ST_EMIT;
            end
            ST_EMIT: begin
               if (emit_go) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_l2_ff    <= (mode_ff == MODE_COSINE) ? '0 : diff_sum_ff;
                  rsp_cos_ff   <= (mode_ff == MODE_COSINE) ? res_cos_ff : '0;
                  rsp_degen_ff <= (mode_ff == MODE_COSINE) && res_degen_ff;
                  rsp_ovf_ff   <= sat_ff;
                  // All sums start over for the next vector pair.
                  diff_sum_ff  <= '0;
                  dot_sum_ff   <= '0;
                  norm_a_ff    <= '0;
                  norm_b_ff    <= '0;
                  count_ff     <= '0;
                  sat_ff       <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

[rtl/core/vcl2d_checker.sv]
`timescale 1ns / 1ps
`include "vector_cosine_l2_distance_macros.svh"

// Port-level checks of the vector distance block.
module vcl2d_checker
   import vcl2d_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             req_last_element,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [ACC_W-1:0] rsp_l2_distance,
   input logic [COS_W-1:0] rsp_cosine_distance,
   input logic             rsp_degenerate
);

   // A result beat that is not taken stays offered.
   `VCL2D_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped")

   // The cosine distance never exceeds 2.0.
   `VCL2D_ASSERT_IMPLY(a_cos_range, clock, reset, rsp_valid, rsp_cosine_distance <= 18'd131072, "cosine out of range")

   // A degenerate result reports exactly 1.0 and no L2 sum.
   `VCL2D_ASSERT_IMPLY(a_degen, clock, reset, rsp_valid && rsp_degenerate, rsp_cosine_distance == 18'd65536 && rsp_l2_distance == 48'd0, "bad degenerate result")

   // A nonzero L2 sum comes only with empty cosine fields.
   `VCL2D_ASSERT_IMPLY(a_l2_excl, clock, reset, rsp_valid && rsp_l2_distance != 48'd0, rsp_cosine_distance == 18'd0 && !rsp_degenerate, "mixed metric result")

   // The last beat of a vector always starts the finishing sequence.
   `VCL2D_ASSERT_NEXT(a_last_busy, clock, reset, req_valid && req_ready && req_last_element, !req_ready, "ready after last beat")

endmodule

bind vector_cosine_l2_distance vcl2d_checker u_vcl2d_checker (.*);

[verif/vector_cosine_l2_distance_test.sv]
`timescale 1ns / 1ps

module vector_cosine_l2_distance_test;
   import vcl2d_pkg::*;

   localparam int ELEM_W        = 16;
   localparam int DIM_LIMIT     = 4096;
   localparam int RANDOM_BEATS  = 1750;
   // Margin after the longest back end pass before a register write.
   localparam int SETTLE_CYCLES = 100;
   localparam int CYCLE_LIMIT   = 4000000;

   localparam longint unsigned U48_TOP    = 64'h0000_FFFF_FFFF_FFFF;
   localparam longint          S48_TOP    = 64'sd140737488355327;
   localparam longint          S48_BOTTOM = -64'sd140737488355328;
   localparam longint unsigned Q16_UNIT   = 64'd65536;

   typedef struct packed {
      logic [ACC_W-1:0] l2;
      logic [COS_W-1:0] cosd;
      logic             degen;
      logic             ovf;
   } distance_result_t;

   typedef enum int {ELEM_FULL, ELEM_SMALL, ELEM_EDGE, ELEM_ZERO, ELEM_MIX} elem_style_t;
   typedef enum bit {ROW_CSR, ROW_BEAT} row_kind_t;

   typedef struct {
      row_kind_t               kind;
      logic [CSR_IDX_W-1:0]    idx;
      logic [CSR_DATA_W-1:0]   data;
      logic signed [ELEM_W-1:0] a;
      logic signed [ELEM_W-1:0] b;
      bit                      last;
      bit                      typed;
      distance_result_t        want;
   } stim_row_t;

   // Block ports.
   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [ELEM_W-1:0]  req_elem_a = '0;
   logic signed [ELEM_W-1:0]  req_elem_b = '0;
   logic                      req_last_element = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [ACC_W-1:0]          rsp_l2_distance;
   logic [COS_W-1:0]          rsp_cosine_distance;
   logic                      rsp_degenerate;
   logic                      rsp_overflow;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;

   // Predictor state and its copy of the registers.
   longint unsigned diff_sq_acc;
   longint          dot_acc;
   longint unsigned norm_a_acc;
   longint unsigned norm_b_acc;
   int unsigned     pair_count;
   bit              sat_seen;
   logic            model_mode;
   logic [31:0]     model_min_den;

   distance_result_t pending_distances[$];
   stim_row_t        directed_rows[$];

   int  error_count   = 0;
   int  beats_sent    = 0;
   int  vectors_sent  = 0;
   int  csr_writes    = 0;
   int  results_seen  = 0;
   int  degen_seen    = 0;
   int  ovf_seen      = 0;
   int  cycle_count   = 0;
   int  rsp_hold      = 0;
   bit  req_quiet     = 1'b0;
   bit  rsp_quiet     = 1'b0;

   vector_cosine_l2_distance #(
      .ELEM_WIDTH (ELEM_W),
      .MAX_DIM    (DIM_LIMIT)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_elem_a          (req_elem_a),
      .req_elem_b          (req_elem_b),
      .req_last_element    (req_last_element),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_l2_distance     (rsp_l2_distance),
      .rsp_cosine_distance (rsp_cosine_distance),
      .rsp_degenerate      (rsp_degenerate),
      .rsp_overflow        (rsp_overflow),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Unsigned 48-bit accumulate that sticks at the top value.
   function automatic longint unsigned sat_add_u48(longint unsigned acc, longint unsigned x);
      if (acc + x > U48_TOP) begin
         sat_seen = 1'b1;
         return U48_TOP;
      end
      return acc + x;
   endfunction

   // Floored square root by the classic bit-pair method.
   function automatic longint unsigned floor_sqrt48(longint unsigned v);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 48;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v    = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   // Advances the distance predictor by one element pair.
   task automatic predict_distance(input logic signed [ELEM_W-1:0] a,
                                   input logic signed [ELEM_W-1:0] b,
                                   input bit last,
                                   output bit has_res,
                                   output distance_result_t res);
      longint          sa;
      longint          sb;
      longint          d;
      longint          sum;
      longint unsigned den;
      longint unsigned mag;
      longint unsigned quo;
      bit              neg;
      sa = a;
      sb = b;
      if (pair_count >= DIM_LIMIT) begin
         sat_seen = 1'b1;
      end else begin
         pair_count++;
         if (model_mode == MODE_L2) begin
            d = sa - sb;
            diff_sq_acc = sat_add_u48(diff_sq_acc, d * d);
         end else begin
            sum = dot_acc + sa * sb;
            if (sum > S48_TOP) begin
               sat_seen = 1'b1;
               sum = S48_TOP;
            end else if (sum < S48_BOTTOM) begin
               sat_seen = 1'b1;
               sum = S48_BOTTOM;
            end
            dot_acc    = sum;
            norm_a_acc = sat_add_u48(norm_a_acc, sa * sa);
            norm_b_acc = sat_add_u48(norm_b_acc, sb * sb);
         end
      end
      has_res = last;
      res = '0;
      if (last) begin
         if (model_mode == MODE_L2) begin
            res.l2 = diff_sq_acc[ACC_W-1:0];
         end else begin
            den = floor_sqrt48(norm_a_acc) * floor_sqrt48(norm_b_acc);
            if (den == 0 || den < model_min_den) begin
               res.cosd  = ONE_Q16;
               res.degen = 1'b1;
            end else begin
               neg = dot_acc < 0;
               mag = neg ? -dot_acc : dot_acc;
               quo = (mag << 16) / den;
               if (quo > Q16_UNIT) quo = Q16_UNIT;
               res.cosd = neg ? Q16_UNIT + quo : Q16_UNIT - quo;
            end
         end
         res.ovf     = sat_seen;
         diff_sq_acc = 0;
         dot_acc     = 0;
         norm_a_acc  = 0;
         norm_b_acc  = 0;
         pair_count  = 0;
         sat_seen    = 1'b0;
      end
   endtask

   // Register writes happen only once the block has drained.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      req_valid <= 1'b0;
      while (pending_distances.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_METRIC_MODE: model_mode = data[0];
         CSR_MIN_DENOM:   model_min_den = data;
         default: ;
      endcase
      csr_writes++;
   endtask

   // Sends one element beat and queues what it should produce.
   task automatic send_beat(input logic signed [ELEM_W-1:0] a,
                            input logic signed [ELEM_W-1:0] b,
                            input bit last,
                            input bit typed,
                            input distance_result_t want);
      int               gap;
      bit               has_res;
      distance_result_t res;
      gap = req_quiet ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_elem_a       <= a;
      req_elem_b       <= b;
      req_last_element <= last;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
      predict_distance(a, b, last, has_res, res);
      if (has_res) begin
         pending_distances.push_back(typed ? want : res);
         vectors_sent++;
      end
   endtask

   function automatic logic signed [ELEM_W-1:0] draw_elem(elem_style_t style);
      if (style == ELEM_MIX) style = elem_style_t'($urandom_range(0, 3));
      case (style)
         ELEM_FULL:  return $urandom_range(0, 65535);
         ELEM_SMALL: return $urandom_range(0, 128) - 64;
         ELEM_EDGE: begin
            case ($urandom_range(0, 4))
               0: return -16'sd32768;
               1: return 16'sd32767;
               2: return 16'sd0;
               3: return -16'sd1;
               default: return 16'sd1;
            endcase
         end
         default: return '0;
      endcase
   endfunction

   // One vector of random content; optionally flips the metric halfway through.
   task automatic send_vector(input int len, input elem_style_t sa, input elem_style_t sb,
                              input bit flip_mid);
      for (int i = 0; i < len; i++) begin
         if (flip_mid && i == len / 2 && i > 0)
            write_csr(CSR_METRIC_MODE, (model_mode == MODE_L2) ? 32'd1 : 32'd0);
         send_beat(draw_elem(sa), draw_elem(sb), i == len - 1, 1'b0, '0);
      end
   endtask

   task automatic csr_row(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      stim_row_t row;
      row = '{kind: ROW_CSR, idx: idx, data: data, a: '0, b: '0, last: 1'b0, typed: 1'b0,
              want: '0};
      directed_rows.push_back(row);
   endtask

   task automatic beat_row(input logic signed [ELEM_W-1:0] a, input logic signed [ELEM_W-1:0] b,
                           input bit last, input bit typed, input logic [ACC_W-1:0] l2,
                           input logic [COS_W-1:0] cosd, input logic degen, input logic ovf);
      stim_row_t row;
      row = '{kind: ROW_BEAT, idx: '0, data: '0, a: a, b: b, last: last, typed: typed,
              want: '{l2: l2, cosd: cosd, degen: degen, ovf: ovf}};
      directed_rows.push_back(row);
   endtask

   task automatic report_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
      if (got !== want) begin
         error_count++;
         if (error_count <= 30)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // Result side: random back-pressure and comparison against the oldest expectation.
   always @(posedge clock) begin : rsp_side
      distance_result_t want;
      int               gap;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= 0;
      end else if (rsp_valid && rsp_ready) begin
         results_seen++;
         if (rsp_degenerate === 1'b1) degen_seen++;
         if (rsp_overflow === 1'b1) ovf_seen++;
         if (pending_distances.size() == 0) begin
            error_count++;
            if (error_count <= 30)
               $display("%0t: result beat with nothing expected, expected none, actual l2=%0d cos=%0d",
                        $time, rsp_l2_distance, rsp_cosine_distance);
         end else begin
            want = pending_distances.pop_front();
            report_field("l2_distance", want.l2, rsp_l2_distance);
            report_field("cosine_distance", want.cosd, rsp_cosine_distance);
            report_field("degenerate", want.degen, rsp_degenerate);
            report_field("overflow", want.ovf, rsp_overflow);
         end
         gap = rsp_quiet ? 0 : $urandom_range(0, 12);
         rsp_hold  <= gap;
         rsp_ready <= (gap == 0);
      end else if (rsp_hold > 1) begin
         rsp_hold <= rsp_hold - 1;
      end else begin
         rsp_hold  <= 0;
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int          phase_start;
      int          phase_len;
      int          cfg_pick;
      int          len;
      int          pick;
      logic [31:0] den_value;
      logic [31:0] hi_bits;
      logic        mode_bit;
      elem_style_t sa;
      elem_style_t sb;

      diff_sq_acc   = 0;
      dot_acc       = 0;
      norm_a_acc    = 0;
      norm_b_acc    = 0;
      pair_count    = 0;
      sat_seen      = 1'b0;
      model_mode    = MODE_L2;
      model_min_den = 32'd1;

      // Directed part: extremes, each metric, degenerate and mid-vector mode cases.
      beat_row(16'sd32767, -16'sd32768, 1, 1, 48'd4294836225, 0, 0, 0);
      beat_row(-16'sd32768, 16'sd32767, 0, 0, 0, 0, 0, 0);
      beat_row(16'sd0, 16'sd0, 1, 1, 48'd4294836225, 0, 0, 0);
      beat_row(16'sh5555, -16'sd21846, 1, 0, 0, 0, 0, 0);
      csr_row(CSR_METRIC_MODE, 32'd1);
      beat_row(16'sd0, 16'sd0, 1, 1, 0, ONE_Q16, 1, 0);
      csr_row(CSR_MIN_DENOM, 32'd0);
      beat_row(16'sd0, 16'sd0, 1, 1, 0, ONE_Q16, 1, 0);
      beat_row(16'sd32767, 16'sd32767, 1, 1, 0, 0, 0, 0);
      beat_row(-16'sd32768, 16'sd32767, 1, 1, 0, 18'd131072, 0, 0);
      beat_row(16'sd256, 16'sd0, 1, 1, 0, ONE_Q16, 1, 0);
      csr_row(CSR_MIN_DENOM, 32'hFFFF_FFFF);
      beat_row(16'sd32767, 16'sd32767, 1, 1, 0, ONE_Q16, 1, 0);
      csr_row(CSR_MIN_DENOM, 32'd1);
      beat_row(16'sd100, 16'sd200, 0, 0, 0, 0, 0, 0);
      beat_row(-16'sd300, 16'sd50, 0, 0, 0, 0, 0, 0);
      beat_row(16'sd7, -16'sd9, 1, 0, 0, 0, 0, 0);
      // The metric changes while a vector is in flight.
      beat_row(16'sd1000, -16'sd1000, 0, 0, 0, 0, 0, 0);
      csr_row(CSR_METRIC_MODE, 32'd0);
      beat_row(16'sd500, 16'sd20, 0, 0, 0, 0, 0, 0);
      csr_row(CSR_METRIC_MODE, 32'd1);
      beat_row(16'sd300, 16'sd300, 1, 0, 0, 0, 0, 0);
      beat_row(16'sd10, 16'sd20, 0, 0, 0, 0, 0, 0);
      csr_row(CSR_METRIC_MODE, 32'd0);
      beat_row(16'sd3, 16'sd4, 1, 0, 0, 0, 0, 0);
      beat_row(-16'sd1, 16'sd1, 1, 1, 48'd4, 0, 0, 0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR)
            write_csr(directed_rows[i].idx, directed_rows[i].data);
         else
            send_beat(directed_rows[i].a, directed_rows[i].b, directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].want);
      end

      // Random phases, each with its own register settings and idling style.
      phase_start = beats_sent;
      while (beats_sent - phase_start < RANDOM_BEATS) begin
         cfg_pick = $urandom_range(0, 5);
         case (cfg_pick)
            0:       den_value = 32'd0;
            1:       den_value = 32'd1;
            2:       den_value = 32'hFFFF_FFFF;
            3:       den_value = $urandom;
            4:       den_value = $urandom_range(0, 4096);
            default: den_value = 32'd1 << $urandom_range(0, 31);
         endcase
         mode_bit = $urandom_range(0, 1);
         hi_bits  = $urandom;
         write_csr(CSR_METRIC_MODE, {hi_bits[31:1], mode_bit});
         write_csr(CSR_MIN_DENOM, den_value);
         req_quiet = ($urandom_range(0, 2) == 0);
         rsp_quiet = ($urandom_range(0, 2) == 0);
         phase_len = $urandom_range(60, 200);
         len = beats_sent;
         while (beats_sent - len < phase_len) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
               sa = ELEM_FULL;
               sb = ELEM_FULL;
            end else if (pick < 7) begin
               sa = ELEM_SMALL;
               sb = ELEM_SMALL;
            end else if (pick == 7) begin
               sa = ELEM_EDGE;
               sb = ELEM_EDGE;
            end else if (pick == 8) begin
               sa = ($urandom_range(0, 1) == 0) ? ELEM_ZERO : ELEM_FULL;
               sb = ELEM_ZERO;
            end else begin
               sa = ELEM_MIX;
               sb = ELEM_MIX;
            end
            send_vector(($urandom_range(0, 7) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8),
                        sa, sb, $urandom_range(0, 15) == 0);
         end
      end

      // Length limit: one vector exactly at the maximum, one just past it.
      req_quiet = 1'b1;
      rsp_quiet = 1'b0;
      write_csr(CSR_METRIC_MODE, {31'd0, 1'($urandom_range(0, 1))});
      write_csr(CSR_MIN_DENOM, 32'd1);
      send_vector(DIM_LIMIT, ELEM_FULL, ELEM_FULL, 1'b0);
      send_vector(DIM_LIMIT + $urandom_range(1, 4), ELEM_MIX, ELEM_MIX, 1'b0);

      // Drain and let any stray result show up.
      req_valid <= 1'b0;
      while (pending_distances.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Streamed %0d element beats forming %0d vectors, with %0d register writes.",
               beats_sent, vectors_sent, csr_writes);
      $display("Checked %0d results: %0d degenerate, %0d with overflow, %0d mismatches.",
               results_seen, degen_seen, ovf_seen, error_count);
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/vcl2d_pkg.sv
rtl/core/vcl2d_mult.sv
rtl/core/vector_cosine_l2_distance.sv
rtl/core/vcl2d_checker.sv
verif/vector_cosine_l2_distance_test.sv
